>>> rtl/dwes_pkg.sv
`timescale 1ns / 1ps
// dwes_pkg: shared widths, register map, reset values and beat types
// for the dual-window seeded moving average block. No dependencies.
package dwes_pkg;

   // field widths fixed by the interface
   localparam int PRICE_W   = 32;
   localparam int WIN_W     = 9;
   localparam int ALPHA_W   = 24;
   localparam int RECIP_W   = 25;
   localparam int SUM_W     = 40;
   localparam int Q_FRAC    = 24;

   // multiplier operand and product widths
   localparam int OPA_W     = (SUM_W > PRICE_W) ? SUM_W : PRICE_W;
   localparam int PROD_W    = OPA_W + RECIP_W;

   // default for the top-level window limit
   localparam int DEF_MAX_WINDOW = 256;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_LONG_WINDOW  = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_WINDOW = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_LONG_ALPHA   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_ALPHA  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LONG_RECIP   = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_SHORT_RECIP  = 3'd5;

   localparam logic [WIN_W-1:0]   RST_LONG_WINDOW  = 9'd200;
   localparam logic [WIN_W-1:0]   RST_SHORT_WINDOW = 9'd50;
   localparam logic [ALPHA_W-1:0] RST_LONG_ALPHA   = 24'd166926;
   localparam logic [ALPHA_W-1:0] RST_SHORT_ALPHA  = 24'd657930;
   localparam logic [RECIP_W-1:0] RST_LONG_RECIP   = 25'd83886;
   localparam logic [RECIP_W-1:0] RST_SHORT_RECIP  = 25'd335544;

   // input beat
   typedef struct packed {
      logic [PRICE_W-1:0] close_price;
      logic [PRICE_W-1:0] adj_price;
   } req_type;

   // result beat
   typedef struct packed {
      logic [PRICE_W-1:0] long_close_avg;
      logic [PRICE_W-1:0] short_close_avg;
      logic [PRICE_W-1:0] long_adj_avg;
      logic [PRICE_W-1:0] short_adj_avg;
      logic               long_ready;
      logic               short_ready;
   } rsp_type;

   // per-window phase for one sample
   typedef struct packed {
      logic add;   // sample still goes into the seed sum
      logic seed;  // sample completes the seed window
      logic upd;   // average already seeded, run the recursive update
   } dwes_ctl_type;

endpackage

>>> rtl/dwes_track.sv
`timescale 1ns / 1ps
// dwes_track: seed sum and moving average of one price series for one window.
// Depends on dwes_pkg for widths and the phase struct.
module dwes_track
   import dwes_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  dwes_ctl_type       ctl,
   input  logic [PRICE_W-1:0] price,
   input  logic [ALPHA_W-1:0] alpha,
   input  logic [RECIP_W-1:0] recip,
   output logic [PRICE_W-1:0] ema_in
);

   localparam int ADD_W = OPA_W + 1;
   localparam int Q_W   = PROD_W + 1 - Q_FRAC;
   localparam logic [ADD_W-1:0]  SUM_MAX = ADD_W'((65'd1 << SUM_W) - 65'd1);
   localparam logic [PROD_W:0]   Q_HALF  = (PROD_W + 1)'(1) << (Q_FRAC - 1);

   logic [SUM_W-1:0]   sum_ff;
   logic [PRICE_W-1:0] ema_ff;

   logic [ADD_W-1:0]   sum_add;
   logic [SUM_W-1:0]   sum_in;
   logic               price_ge;
   logic [PRICE_W-1:0] diff;
   logic [OPA_W-1:0]   mul_a;
   logic [RECIP_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic [PROD_W:0]    prod_rnd;
   logic [Q_W-1:0]     quot;
   logic [PRICE_W-1:0] seed_val;
   logic [PRICE_W-1:0] upd_val;

   // saturating seed sum including this sample
   assign sum_add = ADD_W'(sum_ff) + ADD_W'(price);
   assign sum_in  = (sum_add > SUM_MAX) ? SUM_MAX[SUM_W-1:0] : sum_add[SUM_W-1:0];

   // magnitude of the distance to the current average
   assign price_ge = (price >= ema_ff);
   assign diff     = price_ge ? (price - ema_ff) : (ema_ff - price);

   // one shared multiplier: sum*recip on the seed sample, diff*alpha afterwards
   assign mul_a = ctl.seed ? OPA_W'(sum_in) : OPA_W'(diff);
   assign mul_b = ctl.seed ? recip : RECIP_W'(alpha);
   assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

   // round to nearest, ties up, drop the Q0.24 fraction
   assign prod_rnd = (PROD_W + 1)'(prod) + Q_HALF;
   assign quot     = prod_rnd[PROD_W:Q_FRAC];

   // seed mean clips to the price range
   assign seed_val = (quot[Q_W-1:PRICE_W] != '0) ? '1 : quot[PRICE_W-1:0];

   // step never exceeds diff, so no wrap either way
   assign upd_val = price_ge ? (ema_ff + quot[PRICE_W-1:0])
                             : (ema_ff - quot[PRICE_W-1:0]);

   always_comb begin
      priority if (ctl.seed) begin
         ema_in = seed_val;
      end else if (ctl.upd) begin
         ema_in = upd_val;
      end else begin
         ema_in = ema_ff;
      end
   end

   // state update on each sample that moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         ema_ff <= '0;
      end else if (en) begin
         if (ctl.add) begin
            sum_ff <= sum_in;
         end
         ema_ff <= ema_in;
      end
   end

endmodule

>>> rtl/dual_window_ema_sma_seeded.sv
`timescale 1ns / 1ps
// dual_window_ema_sma_seeded: long and short moving averages of two price series,
// each seeded with the mean of its first window. Uses dwes_pkg and dwes_track.
// Path: input beat goes through the input register, then the result register.
// Throughput: one beat per cycle while rsp_ready holds; the averages and sums update in the
// multiply-round-add path between the two registers.
// Reset: synchronous, clears counter, sums and averages, loads register defaults.
module dual_window_ema_sma_seeded
   import dwes_pkg::*;
#(
   parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int EW    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
   localparam logic [EW-1:0]    WIN_LIM = EW'(MAX_WINDOW);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW);

   // configuration registers
   logic [WIN_W-1:0]   long_window_ff, short_window_ff;
   logic [ALPHA_W-1:0] long_alpha_ff, short_alpha_ff;
   logic [RECIP_W-1:0] long_recip_ff, short_recip_ff;

   logic [REG_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   // pipeline registers
   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_data_ff, out_data_in;
   logic         out_open;
   logic         adv;
   logic         req_fire;

   // sample counter
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // window phase
   logic [EW-1:0]  idx;
   logic [EW-1:0]  lw_raw, sw_raw, lw, sw;
   dwes_ctl_type   ctl_l, ctl_s;
   logic           rdy_l, rdy_s;

   logic [PRICE_W-1:0] lc_ema_in, la_ema_in, sc_ema_in, sa_ema_in;

   // register port decode
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_window_ff  <= RST_LONG_WINDOW;
         short_window_ff <= RST_SHORT_WINDOW;
         long_alpha_ff   <= RST_LONG_ALPHA;
         short_alpha_ff  <= RST_SHORT_ALPHA;
         long_recip_ff   <= RST_LONG_RECIP;
         short_recip_ff  <= RST_SHORT_RECIP;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_LONG_WINDOW:  long_window_ff  <= csr_pwdata[WIN_W-1:0];
            REG_SHORT_WINDOW: short_window_ff <= csr_pwdata[WIN_W-1:0];
            REG_LONG_ALPHA:   long_alpha_ff   <= csr_pwdata[ALPHA_W-1:0];
            REG_SHORT_ALPHA:  short_alpha_ff  <= csr_pwdata[ALPHA_W-1:0];
            REG_LONG_RECIP:   long_recip_ff   <= csr_pwdata[RECIP_W-1:0];
            REG_SHORT_RECIP:  short_recip_ff  <= csr_pwdata[RECIP_W-1:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         REG_LONG_WINDOW:  csr_prdata = CSR_DATA_W'(long_window_ff);
         REG_SHORT_WINDOW: csr_prdata = CSR_DATA_W'(short_window_ff);
         REG_LONG_ALPHA:   csr_prdata = CSR_DATA_W'(long_alpha_ff);
         REG_SHORT_ALPHA:  csr_prdata = CSR_DATA_W'(short_alpha_ff);
         REG_LONG_RECIP:   csr_prdata = CSR_DATA_W'(long_recip_ff);
         REG_SHORT_RECIP:  csr_prdata = CSR_DATA_W'(short_recip_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // handshake: result register frees as it drains, input register refills behind it
   assign out_open     = !out_valid_ff || rsp_ready;
   assign adv          = in_valid_ff && out_open;
   assign req_ready    = !in_valid_ff || adv;
   assign req_fire     = req_valid && req_ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !adv);
   assign out_valid_in = adv || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

   // saturating sample index
   assign cnt_in = (cnt_ff < CNT_MAX) ? (cnt_ff + CNT_W'(1)) : cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (adv) begin
         cnt_ff <= cnt_in;
      end
   end

   // effective windows: zero counts as one, clip at the limit
   assign lw_raw = EW'(long_window_ff);
   assign sw_raw = EW'(short_window_ff);
   assign lw = (lw_raw == '0) ? EW'(1) : ((lw_raw > WIN_LIM) ? WIN_LIM : lw_raw);
   assign sw = (sw_raw == '0) ? EW'(1) : ((sw_raw > WIN_LIM) ? WIN_LIM : sw_raw);
   assign idx = EW'(cnt_ff);

   // phase of this sample within each window
   assign ctl_l.add  = (idx < lw);
   assign ctl_l.seed = (idx == lw - EW'(1));
   assign ctl_l.upd  = (idx >= lw);
   assign ctl_s.add  = (idx < sw);
   assign ctl_s.seed = (idx == sw - EW'(1));
   assign ctl_s.upd  = (idx >= sw);
   assign rdy_l = ctl_l.seed || ctl_l.upd;
   assign rdy_s = ctl_s.seed || ctl_s.upd;

   // four series/window trackers
   dwes_track u_long_close (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .ctl    (ctl_l),
      .price  (in_data_ff.close_price),
      .alpha  (long_alpha_ff),
      .recip  (long_recip_ff),
      .ema_in (lc_ema_in)
   );

   dwes_track u_long_adj (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .ctl    (ctl_l),
      .price  (in_data_ff.adj_price),
      .alpha  (long_alpha_ff),
      .recip  (long_recip_ff),
      .ema_in (la_ema_in)
   );

   dwes_track u_short_close (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .ctl    (ctl_s),
      .price  (in_data_ff.close_price),
      .alpha  (short_alpha_ff),
      .recip  (short_recip_ff),
      .ema_in (sc_ema_in)
   );

   dwes_track u_short_adj (
      .clock  (clock),
      .reset  (reset),
      .en     (adv),
      .ctl    (ctl_s),
      .price  (in_data_ff.adj_price),
      .alpha  (short_alpha_ff),
      .recip  (short_recip_ff),
      .ema_in (sa_ema_in)
   );

   // result beat, averages read zero until seeded
   always_comb begin
      out_data_in.long_close_avg  = rdy_l ? lc_ema_in : '0;
      out_data_in.long_adj_avg    = rdy_l ? la_ema_in : '0;
      out_data_in.short_close_avg = rdy_s ? sc_ema_in : '0;
      out_data_in.short_adj_avg   = rdy_s ? sa_ema_in : '0;
      out_data_in.long_ready      = rdy_l;
      out_data_in.short_ready     = rdy_s;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // counter never passes the window limit
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("sample counter beyond limit");

   // a stalled result holds the counter; the sums and averages hold with it
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(cnt_ff))
      else $error("state moved while result stalled");

   // each sample moved forward bumps the counter below saturation
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      adv && (cnt_ff < CNT_MAX) |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("sample counter missed a step");

   // unseeded short averages read zero
   a_unseeded_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.short_ready |->
         rsp_data.short_close_avg == '0 && rsp_data.short_adj_avg == '0)
      else $error("short average shown before seed");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// testbench: drives dual_window_ema_sma_seeded with price beats and register writes,
// predicts the four seeded averages per beat and checks every result beat.
// Depends on dwes_pkg and the dual_window_ema_sma_seeded top level.
module testbench;
   import dwes_pkg::*;

   // tracks the averages the block should report, one expectation per input beat
   class average_tracker;
      logic [WIN_W-1:0]   long_win, short_win;
      logic [ALPHA_W-1:0] long_alpha, short_alpha;
      logic [RECIP_W-1:0] long_recip, short_recip;
      int unsigned        sample_count;
      logic [SUM_W-1:0]   long_close_sum, long_adj_sum, short_close_sum, short_adj_sum;
      logic [PRICE_W-1:0] long_close_val, long_adj_val, short_close_val, short_adj_val;
      rsp_type            expected_avgs[$];
      int                 mismatches;

      function new();
         long_win        = RST_LONG_WINDOW;
         short_win       = RST_SHORT_WINDOW;
         long_alpha      = RST_LONG_ALPHA;
         short_alpha     = RST_SHORT_ALPHA;
         long_recip      = RST_LONG_RECIP;
         short_recip     = RST_SHORT_RECIP;
         sample_count    = 0;
         long_close_sum  = '0;
         long_adj_sum    = '0;
         short_close_sum = '0;
         short_adj_sum   = '0;
         long_close_val  = '0;
         long_adj_val    = '0;
         short_close_val = '0;
         short_adj_val   = '0;
         mismatches      = 0;
      endfunction

      function void write_reg(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_LONG_WINDOW:  long_win    = val[WIN_W-1:0];
            REG_SHORT_WINDOW: short_win   = val[WIN_W-1:0];
            REG_LONG_ALPHA:   long_alpha  = val[ALPHA_W-1:0];
            REG_SHORT_ALPHA:  short_alpha = val[ALPHA_W-1:0];
            REG_LONG_RECIP:   long_recip  = val[RECIP_W-1:0];
            REG_SHORT_RECIP:  short_recip = val[RECIP_W-1:0];
            default: ;
         endcase
      endfunction

      // zero acts as one, anything past the limit acts as the limit
      function int unsigned clamp_window(logic [WIN_W-1:0] w);
         if (w == 0) return 1;
         if (w > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
         return w;
      endfunction

      // x * r / 2^24 rounded half up on magnitudes
      function logic [41:0] scale_q24(logic [SUM_W-1:0] x, logic [RECIP_W-1:0] r);
         logic [65:0] prod;
         prod = x * r + (66'd1 << 23);
         return prod[65:24];
      endfunction

      function logic [SUM_W-1:0] sum_in(logic [SUM_W-1:0] s, logic [PRICE_W-1:0] p);
         logic [SUM_W:0] t;
         t = s + p;
         return t[SUM_W] ? '1 : t[SUM_W-1:0];
      endfunction

      function logic [PRICE_W-1:0] mean_of(logic [SUM_W-1:0] s, logic [RECIP_W-1:0] r);
         logic [41:0] m;
         m = scale_q24(s, r);
         return (m > 42'hFFFF_FFFF) ? '1 : m[PRICE_W-1:0];
      endfunction

      // moves toward the price by alpha of the distance, never past it
      function logic [PRICE_W-1:0] smooth(logic [PRICE_W-1:0] prev, logic [PRICE_W-1:0] p,
                                          logic [ALPHA_W-1:0] a);
         logic [41:0] d;
         if (p >= prev) begin
            d = scale_q24(SUM_W'(p - prev), RECIP_W'(a));
            return prev + d[PRICE_W-1:0];
         end
         d = scale_q24(SUM_W'(prev - p), RECIP_W'(a));
         return prev - d[PRICE_W-1:0];
      endfunction

      // one window: accumulate until the seed, seed at window-1, then smooth
      function void advance_window(int unsigned idx, int unsigned win,
                                   logic [ALPHA_W-1:0] a, logic [RECIP_W-1:0] r,
                                   logic [PRICE_W-1:0] pc, logic [PRICE_W-1:0] pa,
                                   inout logic [SUM_W-1:0] sc, inout logic [SUM_W-1:0] sa,
                                   inout logic [PRICE_W-1:0] ec,
                                   inout logic [PRICE_W-1:0] ea);
         if (idx < win) begin
            sc = sum_in(sc, pc);
            sa = sum_in(sa, pa);
         end
         if (idx == win - 1) begin
            ec = mean_of(sc, r);
            ea = mean_of(sa, r);
         end else if (idx >= win) begin
            ec = smooth(ec, pc, a);
            ea = smooth(ea, pa, a);
         end
      endfunction

      function void take_sample(req_type beat);
         int unsigned idx, lw, sw;
         rsp_type     avg;
         idx = sample_count;
         lw  = clamp_window(long_win);
         sw  = clamp_window(short_win);
         advance_window(idx, lw, long_alpha, long_recip, beat.close_price, beat.adj_price,
                        long_close_sum, long_adj_sum, long_close_val, long_adj_val);
         advance_window(idx, sw, short_alpha, short_recip, beat.close_price, beat.adj_price,
                        short_close_sum, short_adj_sum, short_close_val, short_adj_val);
         if (sample_count < DEF_MAX_WINDOW) sample_count++;
         avg.long_ready      = (idx >= lw - 1);
         avg.short_ready     = (idx >= sw - 1);
         avg.long_close_avg  = avg.long_ready  ? long_close_val  : '0;
         avg.long_adj_avg    = avg.long_ready  ? long_adj_val    : '0;
         avg.short_close_avg = avg.short_ready ? short_close_val : '0;
         avg.short_adj_avg   = avg.short_ready ? short_adj_val   : '0;
         expected_avgs.insert(expected_avgs.size(), avg);
      endfunction

      function void compare_avgs(rsp_type got);
         rsp_type want;
         if (expected_avgs.size() == 0) begin
            $error("result beat with nothing outstanding: %h", got);
            mismatches++;
            return;
         end
         want = expected_avgs.pop_front();
         if (got.long_close_avg !== want.long_close_avg) begin
            $error("long_close_avg expected %h got %h", want.long_close_avg, got.long_close_avg);
            mismatches++;
         end
         if (got.short_close_avg !== want.short_close_avg) begin
            $error("short_close_avg expected %h got %h",
                   want.short_close_avg, got.short_close_avg);
            mismatches++;
         end
         if (got.long_adj_avg !== want.long_adj_avg) begin
            $error("long_adj_avg expected %h got %h", want.long_adj_avg, got.long_adj_avg);
            mismatches++;
         end
         if (got.short_adj_avg !== want.short_adj_avg) begin
            $error("short_adj_avg expected %h got %h", want.short_adj_avg, got.short_adj_avg);
            mismatches++;
         end
         if (got.long_ready !== want.long_ready) begin
            $error("long_ready expected %b got %b", want.long_ready, got.long_ready);
            mismatches++;
         end
         if (got.short_ready !== want.short_ready) begin
            $error("short_ready expected %b got %b", want.short_ready, got.short_ready);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return expected_avgs.size();
      endfunction
   endclass

   // directed price pairs: extremes, alternating bits, saturating seeds
   localparam logic [PRICE_W-1:0] DIR_CLOSE [16] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001,
      32'h0001_0000, 32'h0001_8000, 32'hFFFF_0000, 32'h1234_5678,
      32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0002};
   localparam logic [PRICE_W-1:0] DIR_ADJ [16] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE,
      32'h0001_0000, 32'h0000_8000, 32'h0000_FFFF, 32'h8765_4321,
      32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0003};

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   average_tracker        tracker;
   bit                    calm = 1'b0;
   bit                    choke_req = 1'b0;
   int                    choke_left = 0;
   int                    hold_left = 0;
   logic [PRICE_W-1:0]    close_prev = 32'h0064_0000;
   logic [PRICE_W-1:0]    adj_prev = 32'h0063_8000;

   dual_window_ema_sma_seeded u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: check each accepted beat, then draw the next hold
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.compare_avgs(rsp_data);
         hold_left = calm ? 0 : $urandom_range(0, 15);
      end
   end

   // result side: drive ready, with one long hold-off on request
   always @(negedge clock) begin
      if (choke_req) begin
         choke_left = 150;
         choke_req  = 1'b0;
      end
      if (choke_left > 0) begin
         rsp_ready = 1'b0;
         choke_left--;
      end else if (hold_left > 0) begin
         rsp_ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // register write: setup cycle then access cycle; starts and ends at a falling edge
   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = val;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.write_reg(idx, val);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic write_settings(logic [CSR_DATA_W-1:0] lw, logic [CSR_DATA_W-1:0] sw,
                                 logic [CSR_DATA_W-1:0] la, logic [CSR_DATA_W-1:0] sa,
                                 logic [CSR_DATA_W-1:0] lr, logic [CSR_DATA_W-1:0] sr);
      csr_write(REG_LONG_WINDOW, lw);
      csr_write(REG_SHORT_WINDOW, sw);
      csr_write(REG_LONG_ALPHA, la);
      csr_write(REG_SHORT_ALPHA, sa);
      csr_write(REG_LONG_RECIP, lr);
      csr_write(REG_SHORT_RECIP, sr);
   endtask

   // one price beat; valid stays up from the previous beat when there is no gap
   task automatic send_beat(req_type beat);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = beat;
      do @(posedge clock); while (!req_ready);
      tracker.take_sample(beat);
      @(negedge clock);
   endtask

   // let every outstanding result drain, then idle
   task automatic drain();
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly a random walk, with full-range jumps and rail values mixed in
   function automatic logic [PRICE_W-1:0] next_price(logic [PRICE_W-1:0] prev);
      logic [PRICE_W-1:0] step;
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
         default: begin
            step = $urandom & ((32'h1 << $urandom_range(0, 20)) - 32'h1);
            return $urandom_range(0, 1) ? prev + step : prev - step;
         end
      endcase
   endfunction

   task automatic run_prices(int count, bit quiet, int choke_at);
      req_type beat;
      calm = quiet;
      for (int i = 0; i < count; i++) begin
         if (i == choke_at) choke_req = 1'b1;
         close_prev       = next_price(close_prev);
         adj_prev         = next_price(adj_prev);
         beat.close_price = close_prev;
         beat.adj_price   = adj_prev;
         send_beat(beat);
      end
      req_valid = 1'b0;
      calm      = 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_window();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return 1;
         2: return DEF_MAX_WINDOW;
         3: return 511;
         default: return $urandom_range(1, 300);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_alpha();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 32'h00FF_FFFF;
         default: return $urandom & 32'h00FF_FFFF;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_recip();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 32'h0100_0000;
         default: return $urandom_range(0, 32'h0100_0000);
      endcase
   endfunction

   initial begin
      req_type beat;
      tracker = new();
      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // window zero for long, long below short, unit recip so short seed saturates,
      // alpha at both rails
      write_settings(0, 3, 0, 32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0000);
      for (int i = 0; i < 16; i++) begin
         beat.close_price = DIR_CLOSE[i];
         beat.adj_price   = DIR_ADJ[i];
         send_beat(beat);
      end
      req_valid = 1'b0;

      // long window above the limit, short window reopened before its new seed
      drain();
      write_settings(300, 40, 130561, 818401, 65536, 419430);
      run_prices(84, 1'b0, -1);

      // long seed index already behind the count, short grows to the limit
      drain();
      write_settings(80, 256, 414252, 130561, 209715, 65536);
      run_prices(200, 1'b0, -1);

      // random settings once the counter has saturated
      for (int p = 0; p < 7; p++) begin
         drain();
         write_settings(pick_window(), pick_window(), pick_alpha(), pick_alpha(),
                        pick_recip(), pick_recip());
         run_prices(230, p == 4, (p == 2) ? 40 : -1);
      end

      drain();
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> files.f
rtl/dwes_pkg.sv
rtl/dwes_track.sv
rtl/dual_window_ema_sma_seeded.sv
dv/testbench.sv
